// ----- rtl/qped_pkg.sv -----
// ----------------------------------------------------------------------------
// qped_pkg
// Shared types and constants for the query parameter extract and decode block.
// ----------------------------------------------------------------------------
package qped_pkg;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       end_of_query;
  } qped_in_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       found;
    logic       last_of_run;
  } qped_out_t;

  localparam logic [1:0] CFG_KEY_LO    = 2'd0;
  localparam logic [1:0] CFG_KEY_HI    = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN   = 2'd2;
  localparam logic [1:0] CFG_VALUE_LIM = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [9:0] VALUE_LIMIT_RESET = 10'd255;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/query_param_extract_decode.sv -----
// ----------------------------------------------------------------------------
// query_param_extract_decode
// Finds a configured key in a URL query stream and emits its decoded value.
// ----------------------------------------------------------------------------
// Query bytes enter one item per clock, unless stalled, into an input register;
// parsing and percent decoding turn each into zero to four result items, loaded
// together into a four-entry result register and shifted out one per clock
// while out_stall is low. An item with at most one result loads as the last
// waiting result leaves; one with k results holds the result register until
// all k are shifted out, so the single result port sets the rate. Items that
// give no result pass even while results are waiting. Keys of up to 16 bytes
// are compared in place; value bytes past RAW_BUFFER_BYTES - 1 are ignored.
module query_param_extract_decode #(
  parameter int KEY_BYTES        = 16,
  parameter int RAW_BUFFER_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qped_pkg::qped_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qped_pkg::qped_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int RawW = $clog2(RAW_BUFFER_BYTES);
  localparam logic [RawW-1:0] RawLast = RawW'(RAW_BUFFER_BYTES - 1);
  localparam int KeyCap = (KEY_BYTES > 31) ? 31 : KEY_BYTES;
  localparam logic [4:0] KeyCapW = 5'(KeyCap);

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [63:0] key_lo_r, key_hi_r;
  logic [4:0]  key_len_r;
  logic [9:0]  value_lim_r;

  logic                in_vld_r;
  qped_pkg::qped_in_t  in_data_r;

  logic [1:0]      phase_r, phase_nxt;
  logic [4:0]      pos_r, pos_nxt;
  logic            mis_r, mis_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [RawW-1:0] raw_r, raw_nxt;
  logic [9:0]      emit_r, emit_nxt;

  qped_pkg::qped_out_t [3:0] bun_r, bun_nxt;
  logic [2:0]                bun_cnt_r, bun_cnt_nxt;

  qped_pkg::qped_out_t [3:0] items;
  logic [2:0]                n_items;
  logic                      take, load_ok, proc_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      key_len_r   <= '0;
      value_lim_r <= qped_pkg::VALUE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qped_pkg::CFG_KEY_LO:    key_lo_r    <= cfg_data;
        qped_pkg::CFG_KEY_HI:    key_hi_r    <= cfg_data;
        qped_pkg::CFG_KEY_LEN:   key_len_r   <= cfg_data[4:0];
        qped_pkg::CFG_VALUE_LIM: value_lim_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]       b;
    logic             eoq;
    logic [4:0]       klen;
    logic [127:0]     kvec;
    logic [7:0]       kb;
    logic [1:0]       ph;
    logic [4:0]       pos;
    logic             mis;
    logic [1:0]       held;
    logic [7:0]       first;
    logic [RawW-1:0]  raw;
    logic [9:0]       e;
    logic [3:0][7:0]  cand;
    logic [2:0]       nc;
    logic             stat, stat_found, fed;
    logic [4:0]       hx_b, hx_f;

    b     = in_data_r.query_byte;
    eoq   = in_data_r.end_of_query;
    klen  = (key_len_r > KeyCapW) ? KeyCapW : key_len_r;
    kvec  = {key_hi_r, key_lo_r};
    ph    = phase_r;
    pos   = pos_r;
    mis   = mis_r;
    held  = held_r;
    first = first_r;
    raw   = raw_r;
    cand  = '0;
    nc    = 3'd0;
    stat  = 1'b0;
    stat_found = 1'b0;
    fed   = 1'b0;
    hx_b  = qped_pkg::hex_digit(b);
    hx_f  = qped_pkg::hex_digit(first_r);
    kb    = pos_r[4] ? 8'h00 : kvec[{pos_r[3:0], 3'b000} +: 8];

    case (phase_r)
      PH_KEY: begin
        if (b == qped_pkg::CH_AMP) begin
          pos = 5'd0;
          mis = 1'b0;
        end else if (pos_r < klen) begin
          if (b != kb) mis = 1'b1;
          pos = pos_r + 5'd1;
        end else if (!mis_r && b == qped_pkg::CH_EQUAL) begin
          ph = PH_VALUE;
        end else begin
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == qped_pkg::CH_AMP) begin
          ph  = PH_KEY;
          pos = 5'd0;
          mis = 1'b0;
        end
      end
      PH_VALUE: begin
        if (b == qped_pkg::CH_AMP) begin
          if (held != 2'd0) begin
            cand[nc[1:0]] = qped_pkg::CH_PERCENT;
            nc = nc + 3'd1;
          end
          if (held == 2'd2) begin
            cand[nc[1:0]] = first;
            nc = nc + 3'd1;
          end
          held = 2'd0;
          stat = 1'b1;
          stat_found = 1'b1;
          ph = PH_DONE;
        end else if (raw_r < RawLast) begin
          raw = raw_r + RawW'(1);
          if (held_r == 2'd1 && hx_b[4]) begin
            first = b;
            held  = 2'd2;
            fed   = 1'b1;
          end else if (held_r == 2'd2 && hx_b[4]) begin
            cand[nc[1:0]] = {hx_f[4] ? hx_f[3:0] : 4'd0, hx_b[3:0]};
            nc   = nc + 3'd1;
            held = 2'd0;
            fed  = 1'b1;
          end else begin
            if (held != 2'd0) begin
              cand[nc[1:0]] = qped_pkg::CH_PERCENT;
              nc = nc + 3'd1;
            end
            if (held == 2'd2) begin
              cand[nc[1:0]] = first;
              nc = nc + 3'd1;
            end
            held = 2'd0;
          end
          if (!fed) begin
            if (b == qped_pkg::CH_PERCENT) begin
              held = 2'd1;
            end else begin
              cand[nc[1:0]] = (b == qped_pkg::CH_PLUS) ? qped_pkg::CH_SPACE : b;
              nc = nc + 3'd1;
            end
          end
          if (raw >= RawLast) begin
            if (held != 2'd0) begin
              cand[nc[1:0]] = qped_pkg::CH_PERCENT;
              nc = nc + 3'd1;
            end
            if (held == 2'd2) begin
              cand[nc[1:0]] = first;
              nc = nc + 3'd1;
            end
            held = 2'd0;
          end
        end
      end
      default: ;
    endcase

    if (eoq) begin
      if (ph == PH_VALUE) begin
        if (held != 2'd0) begin
          cand[nc[1:0]] = qped_pkg::CH_PERCENT;
          nc = nc + 3'd1;
        end
        if (held == 2'd2) begin
          cand[nc[1:0]] = first;
          nc = nc + 3'd1;
        end
        stat = 1'b1;
        stat_found = 1'b1;
      end else if (ph != PH_DONE) begin
        stat = 1'b1;
        stat_found = 1'b0;
      end
    end

    items   = '0;
    n_items = 3'd0;
    e       = emit_r;
    for (int k = 0; k < 3; k++) begin
      if (3'(k) < nc && e < value_lim_r) begin
        items[n_items[1:0]] = '{value_byte: cand[k], byte_valid: 1'b1,
                                found: 1'b0, last_of_run: 1'b0};
        n_items = n_items + 3'd1;
        e = e + 10'd1;
      end
    end
    if (stat) begin
      items[n_items[1:0]] = '{value_byte: 8'h00, byte_valid: 1'b0,
                              found: stat_found, last_of_run: 1'b1};
      n_items = n_items + 3'd1;
    end

    if (eoq) begin
      phase_nxt = PH_KEY;
      pos_nxt   = 5'd0;
      mis_nxt   = 1'b0;
      held_nxt  = 2'd0;
      first_nxt = 8'h00;
      raw_nxt   = '0;
      emit_nxt  = 10'd0;
    end else begin
      phase_nxt = ph;
      pos_nxt   = pos;
      mis_nxt   = mis;
      held_nxt  = held;
      first_nxt = first;
      raw_nxt   = raw;
      emit_nxt  = e;
    end
  end

  assign out_valid = (bun_cnt_r != 3'd0);
  assign out_data  = bun_r[0];
  assign take      = out_valid && !out_stall;
  assign load_ok   = (bun_cnt_r == 3'd0) || (bun_cnt_r == 3'd1 && take);
  assign proc_fire = in_vld_r && ((n_items == 3'd0) || load_ok);
  assign in_stall  = in_vld_r && !proc_fire;

  always_comb begin
    bun_nxt     = bun_r;
    bun_cnt_nxt = bun_cnt_r;
    if (proc_fire && n_items != 3'd0) begin
      bun_nxt     = items;
      bun_cnt_nxt = n_items;
    end else if (take) begin
      for (int k = 0; k < 3; k++) begin
        bun_nxt[k] = bun_r[k+1];
      end
      bun_nxt[3]  = '0;
      bun_cnt_nxt = bun_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      bun_cnt_r <= 3'd0;
      phase_r   <= PH_KEY;
      pos_r     <= 5'd0;
      mis_r     <= 1'b0;
      held_r    <= 2'd0;
      first_r   <= 8'h00;
      raw_r     <= '0;
      emit_r    <= 10'd0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (proc_fire) begin
        in_vld_r <= 1'b0;
      end
      bun_cnt_r <= bun_cnt_nxt;
      if (proc_fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        mis_r   <= mis_nxt;
        held_r  <= held_nxt;
        first_r <= first_nxt;
        raw_r   <= raw_nxt;
        emit_r  <= emit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    bun_r <= bun_nxt;
  end

endmodule

// ----- rtl/qped_checker.sv -----
// ----------------------------------------------------------------------------
// qped_checker
// Port-level checks for the query parameter extract and decode block.
// ----------------------------------------------------------------------------
module qped_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input qped_pkg::qped_out_t  out_data
);

  a_data_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |-> !out_data.found && !out_data.last_of_run)
    else $error("Data item carries status flags.");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last_of_run && out_data.value_byte == 8'h00)
    else $error("Status item is malformed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result item changed.");

endmodule

bind query_param_extract_decode qped_checker u_qped_checker (.*);
